// File: rtl/sorted_key_handler_table_macros.svh
// assertion macros for the sorted key/handler table
`ifndef SORTED_KEY_HANDLER_TABLE_MACROS_SVH
`define SORTED_KEY_HANDLER_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition must hold at every clock edge outside reset
`define SKHT_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SKHT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define SKHT_CHECK(label, cond, msg)
`define SKHT_IMPLY(label, ante, cons, msg)

`endif

`endif

// File: rtl/skht_pkg.sv
// shared types, sizes and codes of the sorted key/handler table
package skht_pkg;

  localparam int unsigned TABLE_DEPTH = 128;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned HID_W       = 16;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned STAT_W      = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STAT_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STAT_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NEW      = 3'd2;
  localparam logic [STAT_W-1:0] ST_REPLACED = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
    logic [HID_W-1:0] handler_id;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [HID_W-1:0]  handler_out;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  entries_now;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [HID_W-1:0] handler;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/skht_ram.sv
// generic single write, single read ram with registered read data
module skht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/sorted_key_handler_table.sv
// top level of the sorted key/handler table: search and shift sequencer around one ram
//
// keeps up to TABLE_DEPTH (key, handler) pairs in ascending key order in a single
// 48-bit wide ram with one write and one registered read port. a request is taken
// when start is high and busy is low; each request gives exactly one result on
// result, marked by a one-cycle done strobe that the receiver cannot stall.
// steps per request: each halving step of the binary search reads the probe and
// then compares it; a final read fetches the lower bound and a last step evaluates
// it. a lookup or a replace then finishes. a new key shifts the entries above its
// slot up by one through the ram port pair, one entry per cycle, then drains the
// last shifted entry and places the new one. an insert into a full table is
// rejected in the cycle it is taken and never searches.
// the ram is not cleared after reset; a slot at or above the entry count may be read, but is never taken as a hit.
`include "sorted_key_handler_table_macros.svh"

module sorted_key_handler_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  skht_pkg::req_t request,
  output logic          done,
  output skht_pkg::rsp_t result
);

  localparam int unsigned IDX_W = skht_pkg::IDX_W;
  localparam int unsigned CNT_W = skht_pkg::CNT_W;
  localparam int unsigned POS_W = skht_pkg::POS_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_PLACE  = 3'd5;

  logic [2:0]         state, state_next;
  logic [CNT_W-1:0]   count, count_next;     // valid entries
  logic [CNT_W-1:0]   lo, lo_next;           // search window low bound
  logic [CNT_W-1:0]   hi, hi_next;           // search window high bound (exclusive)
  logic [CNT_W-1:0]   mid, mid_next;         // probe index of the current step
  logic [CNT_W-1:0]   j, j_next;             // shift cursor, slot to be filled
  logic               wpend, wpend_next;     // a shifted entry waits to be written
  logic [IDX_W-1:0]   waddr, waddr_next;     // its destination slot
  skht_pkg::req_t     req_q, req_next;
  logic               done_next;
  skht_pkg::rsp_t     result_next;

  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid_calc;
  logic [CNT_W-1:0]   j_dec;
  logic               hit;

  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  skht_pkg::entry_t          wr_data;
  logic [IDX_W-1:0]          rd_addr;
  skht_pkg::entry_t          rd_entry;
  logic [skht_pkg::ENTRY_W-1:0] rd_raw;

  skht_ram #(
    .WIDTH (skht_pkg::ENTRY_W),
    .DEPTH (skht_pkg::TABLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_entry = rd_raw;
  assign busy     = (state != S_IDLE);

  // midpoint of the window; lo + hi never overflows the extra bit
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_calc = mid_sum[CNT_W:1];
  assign j_dec    = j - CNT_W'(1);

  // equality is only meaningful for a slot below the count
  assign hit = (lo < count) && (rd_entry.key == req_q.key);

  always_comb begin
    state_next  = state;
    count_next  = count;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    j_next      = j;
    wpend_next  = wpend;
    waddr_next  = waddr;
    req_next    = req_q;
    done_next   = 1'b0;
    result_next = result;
    rd_addr     = lo[IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = waddr;
    wr_data     = rd_entry;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_next = request;
          lo_next  = '0;
          hi_next  = count;
          if ((request.operation == skht_pkg::OP_INSERT) &&
              (count == CNT_W'(skht_pkg::TABLE_DEPTH))) begin
            // full table: reject without searching, even for a present key
            done_next               = 1'b1;
            result_next.status      = skht_pkg::ST_FULL;
            result_next.handler_out = '0;
            result_next.position    = '0;
            result_next.entries_now = POS_W'(count);
          end else begin
            state_next = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        if (lo < hi) begin
          mid_next   = mid_calc;
          rd_addr    = mid_calc[IDX_W-1:0];
          state_next = S_WAIT;
        end else begin
          // window closed: lo is the lower bound, fetch it for the equality test
          rd_addr    = lo[IDX_W-1:0];
          state_next = S_EVAL;
        end
      end

      S_WAIT: begin
        if (rd_entry.key < req_q.key) begin
          lo_next = mid + CNT_W'(1);
        end else begin
          hi_next = mid;
        end
        state_next = S_SEARCH;
      end

      S_EVAL: begin
        if (req_q.operation == skht_pkg::OP_LOOKUP) begin
          done_next               = 1'b1;
          result_next.status      = hit ? skht_pkg::ST_HIT : skht_pkg::ST_MISS;
          result_next.handler_out = hit ? rd_entry.handler : '0;
          result_next.position    = POS_W'(lo);
          result_next.entries_now = POS_W'(count);
          state_next              = S_IDLE;
        end else if (hit) begin
          // existing key: overwrite in place
          wr_en                   = 1'b1;
          wr_addr                 = lo[IDX_W-1:0];
          wr_data.key             = req_q.key;
          wr_data.handler         = req_q.handler_id;
          done_next               = 1'b1;
          result_next.status      = skht_pkg::ST_REPLACED;
          result_next.handler_out = '0;
          result_next.position    = POS_W'(lo);
          result_next.entries_now = POS_W'(count);
          state_next              = S_IDLE;
        end else begin
          j_next     = count;
          wpend_next = 1'b0;
          state_next = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // read slot j-1 while writing the previously read entry one slot up;
        // reads move downward ahead of the writes, so they never collide
        if (wpend) begin
          wr_en   = 1'b1;
          wr_addr = waddr;
          wr_data = rd_entry;
        end
        if (j > lo) begin
          rd_addr    = j_dec[IDX_W-1:0];
          waddr_next = j[IDX_W-1:0];
          wpend_next = 1'b1;
          j_next     = j_dec;
        end else begin
          wpend_next = 1'b0;
          if (!wpend) begin
            state_next = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        wr_en                   = 1'b1;
        wr_addr                 = lo[IDX_W-1:0];
        wr_data.key             = req_q.key;
        wr_data.handler         = req_q.handler_id;
        count_next              = count + CNT_W'(1);
        done_next               = 1'b1;
        result_next.status      = skht_pkg::ST_NEW;
        result_next.handler_out = '0;
        result_next.position    = POS_W'(lo);
        result_next.entries_now = POS_W'(count + CNT_W'(1));
        state_next              = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      wpend <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      wpend <= wpend_next;
      done  <= done_next;
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    j      <= j_next;
    waddr  <= waddr_next;
    req_q  <= req_next;
    result <= result_next;
  end

  `SKHT_CHECK(a_count_bound, count <= CNT_W'(skht_pkg::TABLE_DEPTH), "entry count above depth")
  `SKHT_IMPLY(a_search_window, state == S_SEARCH, lo <= hi, "search window inverted")
  `SKHT_IMPLY(a_write_state, wr_en, (state == S_EVAL) || (state == S_SHIFT) || (state == S_PLACE), "ram write outside update states")
  `SKHT_IMPLY(a_new_grows, done && (result.status == skht_pkg::ST_NEW), count == CNT_W'($past(count) + CNT_W'(1)), "new entry without count growth")

endmodule
